[hdl/hsps_pkg.sv]
// ----------------------------------------------------------------------------
// hsps_pkg
// Shared types, register indexes, strategy codes and fixed-point constants
// for the hybrid storage power split block.
// ----------------------------------------------------------------------------
package hsps_pkg;

   // register indexes
   localparam logic [2:0] REG_STRATEGY        = 3'd0;
   localparam logic [2:0] REG_DISCHARGE_LIMIT = 3'd1;
   localparam logic [2:0] REG_CHARGE_LIMIT    = 3'd2;
   localparam logic [2:0] REG_CAP_REFERENCE   = 3'd3;
   localparam logic [2:0] REG_CAP_FLOOR       = 3'd4;
   localparam logic [2:0] REG_CAP_CEILING     = 3'd5;
   localparam logic [2:0] REG_BAND_LOW        = 3'd6;
   localparam logic [2:0] REG_BAND_HIGH       = 3'd7;

   // strategy codes
   localparam logic [2:0] STRAT_THRESHOLD  = 3'd1;
   localparam logic [2:0] STRAT_CAP_FIRST  = 3'd2;
   localparam logic [2:0] STRAT_PI_FIXED   = 3'd3;
   localparam logic [2:0] STRAT_PI_SPEED   = 3'd4;
   localparam logic [2:0] STRAT_HYSTERESIS = 3'd5;

   // reset values
   localparam logic [2:0]  RST_STRATEGY        = STRAT_THRESHOLD;
   localparam logic [19:0] RST_DISCHARGE_LIMIT = 20'd20000;
   localparam logic [19:0] RST_CHARGE_LIMIT    = 20'd10000;
   localparam logic [15:0] RST_CAP_REFERENCE   = 16'd30000;
   localparam logic [15:0] RST_CAP_FLOOR       = 16'd20000;
   localparam logic [15:0] RST_CAP_CEILING     = 16'd40000;
   localparam logic [15:0] RST_BAND_LOW        = 16'd28000;
   localparam logic [15:0] RST_BAND_HIGH       = 16'd32000;

   // threshold current: limit * 950 / 375 = floor(limit * 38 / 15)
   localparam logic [25:0] TH_GAIN  = 26'd38;
   localparam int          TH_SHIFT = 30;
   localparam logic [26:0] TH_RECIP = 27'(((64'd1 << TH_SHIFT) + 64'd14) / 64'd15);

   // pi law
   localparam logic [13:0] SOC_FULL     = 14'd9999;
   localparam logic [16:0] SPEED_BASE   = 17'd35000;
   localparam logic [16:0] SPEED_STEP   = 17'd100;
   localparam logic signed [23:0] PI_PGAIN = 24'sd100;
   localparam logic signed [39:0] INTEG_MAX = {1'b0, {39{1'b1}}};
   localparam logic signed [39:0] INTEG_MIN = {1'b1, {39{1'b0}}};

   // divide by 1000: (x >> 3) / 125 by reciprocal, exact for x < 2^40
   localparam int          DIV_SHIFT = 44;
   localparam logic [37:0] DIV_RECIP = 38'(((64'd1 << DIV_SHIFT) + 64'd124) / 64'd125);

   // hysteresis
   localparam logic [15:0] HYST_CLAMP = 16'd2000;

   typedef struct packed {
      logic [2:0]  strategy;
      logic [19:0] discharge_power_limit;
      logic [19:0] charge_power_limit;
      logic [15:0] cap_voltage_reference;
      logic [15:0] cap_voltage_floor;
      logic [15:0] cap_voltage_ceiling;
      logic [15:0] band_low;
      logic [15:0] band_high;
   } cfg_type;

   typedef struct packed {
      logic        regulator_is_cap;
      logic        command_target;
      logic        command_is_charge;
      logic        use_div;
      logic        quot_neg;
      logic [22:0] direct_current;
      logic [39:0] magnitude;
   } dec_type;

endpackage

[hdl/hsps_csr.sv]
// ----------------------------------------------------------------------------
// hsps_csr
// Configuration register file, written through a plain index/data port.
// ----------------------------------------------------------------------------
module hsps_csr (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [2:0]            csr_index,
   input  logic [19:0]           csr_data,
   output hsps_pkg::cfg_type     cfg
);

   hsps_pkg::cfg_type cfg_ff;
   hsps_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            hsps_pkg::REG_STRATEGY:        cfg_in.strategy              = csr_data[2:0];
            hsps_pkg::REG_DISCHARGE_LIMIT: cfg_in.discharge_power_limit = csr_data;
            hsps_pkg::REG_CHARGE_LIMIT:    cfg_in.charge_power_limit    = csr_data;
            hsps_pkg::REG_CAP_REFERENCE:   cfg_in.cap_voltage_reference = csr_data[15:0];
            hsps_pkg::REG_CAP_FLOOR:       cfg_in.cap_voltage_floor     = csr_data[15:0];
            hsps_pkg::REG_CAP_CEILING:     cfg_in.cap_voltage_ceiling   = csr_data[15:0];
            hsps_pkg::REG_BAND_LOW:        cfg_in.band_low              = csr_data[15:0];
            hsps_pkg::REG_BAND_HIGH:       cfg_in.band_high             = csr_data[15:0];
            default:                       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.strategy              <= hsps_pkg::RST_STRATEGY;
         cfg_ff.discharge_power_limit <= hsps_pkg::RST_DISCHARGE_LIMIT;
         cfg_ff.charge_power_limit    <= hsps_pkg::RST_CHARGE_LIMIT;
         cfg_ff.cap_voltage_reference <= hsps_pkg::RST_CAP_REFERENCE;
         cfg_ff.cap_voltage_floor     <= hsps_pkg::RST_CAP_FLOOR;
         cfg_ff.cap_voltage_ceiling   <= hsps_pkg::RST_CAP_CEILING;
         cfg_ff.band_low              <= hsps_pkg::RST_BAND_LOW;
         cfg_ff.band_high             <= hsps_pkg::RST_BAND_HIGH;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/hsps_decide.sv]
// ----------------------------------------------------------------------------
// hsps_decide
// Strategy decision for one epoch, threshold current, hysteresis current and
// the PI numerator, with the saturating error integral.
// ----------------------------------------------------------------------------
module hsps_decide (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  logic                  advance,
   input  logic signed [19:0]    load_power,
   input  logic [19:0]           regen_power,
   input  logic [15:0]           cap_voltage,
   input  logic [13:0]           battery_charge,
   input  logic [7:0]            vehicle_speed,
   input  hsps_pkg::cfg_type     cfg,
   output hsps_pkg::dec_type     dec
);

   logic                load_pos;
   logic                regen_nz;
   logic                battery_first;
   logic                guard;
   logic [19:0]         lim_sel;
   logic [25:0]         th_x;
   logic [52:0]         th_prod;
   logic [22:0]         th_cur;
   logic [15:0]         dis_diff;
   logic [15:0]         chg_diff;
   logic [10:0]         dis_clamp;
   logic [10:0]         chg_clamp;
   logic [15:0]         speed_ref;
   logic [15:0]         volt_ref;
   logic signed [16:0]  err;
   logic signed [40:0]  sum_wide;
   logic signed [39:0]  integral_ff;
   logic signed [39:0]  integral_in;
   logic signed [23:0]  p_term;
   logic signed [40:0]  numer;
   logic [39:0]         mag;
   logic                pi_active;

   assign load_pos = !load_power[19] && (load_power != 20'sd0);
   assign regen_nz = (regen_power != 20'd0);

   assign guard = (load_pos && (cap_voltage < cfg.cap_voltage_floor)) ||
                  (regen_nz && (cap_voltage > cfg.cap_voltage_ceiling));

   assign battery_first =
      (load_pos && (20'(load_power) <= cfg.discharge_power_limit)) ||
      (regen_nz && (regen_power <= cfg.charge_power_limit) &&
       (battery_charge < hsps_pkg::SOC_FULL)) || guard;

   // threshold current
   assign lim_sel = load_pos ? cfg.discharge_power_limit : cfg.charge_power_limit;
   assign th_x    = 26'(lim_sel) * hsps_pkg::TH_GAIN;
   assign th_prod = 53'(th_x) * 53'(hsps_pkg::TH_RECIP);
   assign th_cur  = th_prod[52:30];

   // hysteresis currents
   assign dis_diff  = cfg.band_low - cap_voltage;
   assign chg_diff  = cap_voltage - cfg.band_high;
   assign dis_clamp = (dis_diff > hsps_pkg::HYST_CLAMP) ? 11'(hsps_pkg::HYST_CLAMP)
                                                         : dis_diff[10:0];
   assign chg_clamp = (chg_diff > hsps_pkg::HYST_CLAMP) ? 11'(hsps_pkg::HYST_CLAMP)
                                                         : chg_diff[10:0];

   // pi numerator
   assign speed_ref = 16'(hsps_pkg::SPEED_BASE - 17'(vehicle_speed) * hsps_pkg::SPEED_STEP);
   assign volt_ref  = (cfg.strategy == hsps_pkg::STRAT_PI_FIXED) ? cfg.cap_voltage_reference
                                                                  : speed_ref;
   assign err       = $signed({1'b0, cap_voltage}) - $signed({1'b0, volt_ref});
   assign sum_wide  = 41'(integral_ff) + 41'(err);

   always_comb begin
      if (sum_wide[40] != sum_wide[39]) begin
         integral_in = sum_wide[40] ? hsps_pkg::INTEG_MIN : hsps_pkg::INTEG_MAX;
      end else begin
         integral_in = sum_wide[39:0];
      end
   end

   assign p_term = 24'(err) * hsps_pkg::PI_PGAIN;
   assign numer  = 41'(integral_in) + 41'(p_term);
   assign mag    = numer[40] ? 40'(-numer) : 40'(numer);

   always_comb begin
      dec       = '0;
      pi_active = 1'b0;
      case (cfg.strategy)
         hsps_pkg::STRAT_THRESHOLD: begin
            if (!battery_first) begin
               dec.regulator_is_cap = 1'b1;
               dec.command_target   = 1'b1;
               if (load_pos) begin
                  dec.direct_current = th_cur;
               end else if (regen_nz) begin
                  dec.command_is_charge = 1'b1;
                  dec.direct_current    = th_cur;
               end
            end
         end
         hsps_pkg::STRAT_CAP_FIRST: begin
            if ((load_pos && (cap_voltage > cfg.cap_voltage_floor)) ||
                (regen_nz && (cap_voltage < cfg.cap_voltage_ceiling))) begin
               dec.regulator_is_cap = 1'b1;
               dec.command_target   = 1'b1;
            end
         end
         hsps_pkg::STRAT_PI_FIXED, hsps_pkg::STRAT_PI_SPEED: begin
            if (!guard) begin
               dec.regulator_is_cap = 1'b1;
               dec.command_target   = 1'b1;
               dec.use_div          = 1'b1;
               dec.quot_neg         = !numer[40];
               dec.magnitude        = mag;
               pi_active            = 1'b1;
            end
         end
         hsps_pkg::STRAT_HYSTERESIS: begin
            if (!guard) begin
               dec.regulator_is_cap = 1'b1;
               dec.command_target   = 1'b1;
               if ((cap_voltage > cfg.band_low) && (cap_voltage < cfg.band_high)) begin
                  dec.direct_current = '0;
               end else if (cap_voltage <= cfg.band_low) begin
                  dec.direct_current = 23'({dis_clamp, 4'b0000});
               end else begin
                  dec.command_is_charge = 1'b1;
                  dec.direct_current    = 23'({chg_clamp, 4'b0000});
               end
            end
         end
         default: begin
            dec = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integral_ff <= '0;
      end else if (in_valid && advance && pi_active) begin
         integral_ff <= integral_in;
      end
   end

   a_integral_hold: assert property (@(posedge clock) disable iff (reset)
      !(in_valid && advance) |=> $stable(integral_ff))
      else $error("error integral moved without a stage transfer");

endmodule

[hdl/hsps_div.sv]
// ----------------------------------------------------------------------------
// hsps_div
// Divide-by-1000 of a 40-bit magnitude by reciprocal multiplication, split
// into four registered partial products and one summing step.
// ----------------------------------------------------------------------------
module hsps_div (
   input  logic         clock,
   input  logic         enable,
   input  logic [39:0]  magnitude,
   output logic [30:0]  quotient
);

   logic [36:0] b_val;
   logic [18:0] b_lo;
   logic [17:0] b_hi;
   logic [18:0] m_lo;
   logic [18:0] m_hi;
   logic [37:0] pp_ll_ff;
   logic [37:0] pp_lh_ff;
   logic [36:0] pp_hl_ff;
   logic [36:0] pp_hh_ff;
   logic [74:0] sum;

   assign b_val = magnitude[39:3];
   assign b_lo  = b_val[18:0];
   assign b_hi  = b_val[36:19];
   assign m_lo  = hsps_pkg::DIV_RECIP[18:0];
   assign m_hi  = hsps_pkg::DIV_RECIP[37:19];

   always_ff @(posedge clock) begin
      if (enable) begin
         pp_ll_ff <= 38'(b_lo) * 38'(m_lo);
         pp_lh_ff <= 38'(b_lo) * 38'(m_hi);
         pp_hl_ff <= 37'(b_hi) * 37'(m_lo);
         pp_hh_ff <= 37'(b_hi) * 37'(m_hi);
      end
   end

   assign sum = (75'(pp_hh_ff) << 38) + (75'(pp_lh_ff) << 19) +
                (75'(pp_hl_ff) << 19) + 75'(pp_ll_ff);
   assign quotient = sum[74:44];

endmodule

[hdl/hybrid_storage_power_split_top.sv]
// ----------------------------------------------------------------------------
// hybrid_storage_power_split_top
// Battery plus supercap power split: input register, decision stage,
// divider stage and result register, one epoch per transfer.
// ----------------------------------------------------------------------------
// throughput: one item per cycle while rsp_stall is low; the four-stage
//   pipeline with per-stage handshake takes up to three more items while a
//   result waits on rsp_stall
// reset: pipeline empties, registers take their defaults, error integral
//   clears to zero
module hybrid_storage_power_split_top (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic signed [19:0]  req_load_power,
   input  logic [19:0]         req_regen_power,
   input  logic [15:0]         req_cap_voltage,
   input  logic [13:0]         req_battery_charge,
   input  logic [7:0]          req_vehicle_speed,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_regulator_is_cap,
   output logic                rsp_command_target,
   output logic                rsp_command_is_charge,
   output logic signed [31:0]  rsp_current_command,
   input  logic                csr_write,
   input  logic [2:0]          csr_index,
   input  logic [19:0]         csr_data
);

   hsps_pkg::cfg_type  cfg;
   hsps_pkg::dec_type  dec;
   hsps_pkg::dec_type  s1_dec_ff;
   hsps_pkg::dec_type  s2_dec_ff;

   logic                s0_valid_ff;
   logic                s1_valid_ff;
   logic                s2_valid_ff;
   logic                rsp_valid_ff;
   logic                s0_ready;
   logic                s1_ready;
   logic                s2_ready;
   logic                rsp_ready;
   logic signed [19:0]  s0_load_ff;
   logic [19:0]         s0_regen_ff;
   logic [15:0]         s0_volt_ff;
   logic [13:0]         s0_charge_ff;
   logic [7:0]          s0_speed_ff;
   logic [30:0]         quotient;
   logic signed [31:0]  current_in;
   logic                reg_cap_ff;
   logic                target_ff;
   logic                charge_ff;
   logic signed [31:0]  current_ff;

   // stage handshake
   assign rsp_ready = !rsp_valid_ff || !rsp_stall;
   assign s2_ready  = !s2_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;
   assign req_stall = !s0_ready;

   hsps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   hsps_decide u_decide (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (s0_valid_ff),
      .advance        (s1_ready),
      .load_power     (s0_load_ff),
      .regen_power    (s0_regen_ff),
      .cap_voltage    (s0_volt_ff),
      .battery_charge (s0_charge_ff),
      .vehicle_speed  (s0_speed_ff),
      .cfg            (cfg),
      .dec            (dec)
   );

   hsps_div u_div (
      .clock     (clock),
      .enable    (s2_ready),
      .magnitude (s1_dec_ff.magnitude),
      .quotient  (quotient)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s0_ready) begin
            s0_valid_ff <= req_valid;
         end
         if (s1_ready) begin
            s1_valid_ff <= s0_valid_ff;
         end
         if (s2_ready) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rsp_ready) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s0_ready) begin
         s0_load_ff   <= req_load_power;
         s0_regen_ff  <= req_regen_power;
         s0_volt_ff   <= req_cap_voltage;
         s0_charge_ff <= req_battery_charge;
         s0_speed_ff  <= req_vehicle_speed;
      end
      if (s1_ready) begin
         s1_dec_ff <= dec;
      end
      if (s2_ready) begin
         s2_dec_ff <= s1_dec_ff;
      end
      if (rsp_ready) begin
         reg_cap_ff <= s2_dec_ff.regulator_is_cap;
         target_ff  <= s2_dec_ff.command_target;
         charge_ff  <= s2_dec_ff.command_is_charge;
         current_ff <= current_in;
      end
   end

   always_comb begin
      if (s2_dec_ff.use_div) begin
         current_in = s2_dec_ff.quot_neg ? -$signed(32'(quotient)) : $signed(32'(quotient));
      end else begin
         current_in = $signed(32'(s2_dec_ff.direct_current));
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_regulator_is_cap  = reg_cap_ff;
   assign rsp_command_target    = target_ff;
   assign rsp_command_is_charge = charge_ff;
   assign rsp_current_command   = current_ff;

   a_empty_input_open: assert property (@(posedge clock) disable iff (reset)
      !s0_valid_ff |-> !req_stall)
      else $error("input stalled with an empty input register");

   a_battery_idle_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_regulator_is_cap |->
         (rsp_current_command == 32'sd0) && !rsp_command_target && !rsp_command_is_charge)
      else $error("battery regulation with a nonzero supercap command");

   a_charge_cmd_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_command_is_charge |->
         rsp_regulator_is_cap && rsp_command_target && !rsp_current_command[31])
      else $error("charge command with wrong target or negative current");

endmodule
